FILE: hdl/ghnp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ghnp_pkg
// Shared types, codes and default sizes for the grid-hash nearest-point unit.
// ----------------------------------------------------------------------------
package ghnp_pkg;

	localparam int HASH_RES_DEF     = 8;
	localparam int MAX_POINTS_DEF   = 4096;
	localparam int BUCKET_SLOTS_DEF = 16;
	localparam int MAX_SHELL_DEF    = 4;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_LOADED   = 2'd0,
		ST_REJECTED = 2'd1,
		ST_FOUND    = 2'd2,
		ST_NONE     = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LD_RD,
		S_LD_CHK,
		S_Q_POS,
		S_Q_FILL,
		S_Q_SLOT,
		S_Q_PT,
		S_Q_SQ,
		S_Q_CMP,
		S_Q_ADV,
		S_Q_SHELL
	} state_t;

	typedef struct packed {
		logic clr_en;
		logic capture;
		logic q_init;
		logic ld_commit;
		logic ld_finish;
		logic pos_sel;
		logic k_clear;
		logic cmp_en;
		logic step;
		logic shell_next;
		logic q_finish;
	} ctl_t;

	typedef struct packed {
		logic clr_last;
		logic full;
		logic pos_skip;
		logic fill_zero;
		logic k_last;
		logic pos_last;
		logic stop_ok;
		logic shell_max;
	} stat_t;

endpackage
`default_nettype wire

FILE: hdl/grid_hash_nearest_point_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_hash_nearest_point_unit
// Uniform 3-D bucket grid: loads points and answers nearest-point queries.
// ----------------------------------------------------------------------------
// channel   ports                          beat taken when
// item in   start busy cmd px py pz        start && !busy
// result    done status point_index dist_sq  done (one cycle, no hold-off)
//
// A load goes through a fill read, a check and commit, and the result.
// A query visits each grid position on a shell (select, advance), with a fill
// count read for each position inside the grid, reads each stored point of a
// bucket in steps (slot read, point read, square, compare), checks the stop
// rule after each shell and ends with the result.
// After reset the bucket fill counts are cleared, one bucket a cycle
// (HASH_RES^3 buckets, 512 by default), with busy high.
// done pulses for one cycle; results cannot be stalled.
// ----------------------------------------------------------------------------
module grid_hash_nearest_point_unit #(
	parameter int HASH_RES     = ghnp_pkg::HASH_RES_DEF,
	parameter int MAX_POINTS   = ghnp_pkg::MAX_POINTS_DEF,
	parameter int BUCKET_SLOTS = ghnp_pkg::BUCKET_SLOTS_DEF,
	parameter int MAX_SHELL    = ghnp_pkg::MAX_SHELL_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               cmd,
	input  wire logic signed [15:0] px,
	input  wire logic signed [15:0] py,
	input  wire logic signed [15:0] pz,
	output logic                    done,
	output logic [1:0]              status,
	output logic [11:0]             point_index,
	output logic [31:0]             dist_sq
);

	ghnp_pkg::ctl_t  ctl;
	ghnp_pkg::stat_t st;

	ghnp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.st     (st),
		.ctl    (ctl),
		.busy   (busy)
	);

	ghnp_dpath #(
		.HASH_RES     (HASH_RES),
		.MAX_POINTS   (MAX_POINTS),
		.BUCKET_SLOTS (BUCKET_SLOTS),
		.MAX_SHELL    (MAX_SHELL)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.st          (st),
		.px          (px),
		.py          (py),
		.pz          (pz),
		.done        (done),
		.status      (status),
		.point_index (point_index),
		.dist_sq     (dist_sq)
	);

endmodule
`default_nettype wire

FILE: hdl/ghnp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ghnp_ctrl
// Sequencer: bucket clear after reset, load commit, shell/bucket/slot walk.
// ----------------------------------------------------------------------------
module ghnp_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            cmd,
	input  wire ghnp_pkg::stat_t st,
	output ghnp_pkg::ctl_t       ctl,
	output logic                 busy
);

	ghnp_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ghnp_pkg::S_CLEAR;
		else state_q <= state_nx;
	end

	assign busy = (state_q != ghnp_pkg::S_IDLE);

	always_comb begin
		state_nx = state_q;
		ctl = '0;
		case (state_q)
			ghnp_pkg::S_CLEAR: begin
				ctl.clr_en = 1'b1;
				if (st.clr_last) state_nx = ghnp_pkg::S_IDLE;
			end
			ghnp_pkg::S_IDLE: begin
				if (start) begin
					ctl.capture = 1'b1;
					if (cmd == ghnp_pkg::CMD_QUERY) begin
						ctl.q_init = 1'b1;
						state_nx = ghnp_pkg::S_Q_POS;
					end else begin
						state_nx = ghnp_pkg::S_LD_RD;
					end
				end
			end
			ghnp_pkg::S_LD_RD: state_nx = ghnp_pkg::S_LD_CHK;
			ghnp_pkg::S_LD_CHK: begin
				ctl.ld_commit = !st.full;
				ctl.ld_finish = 1'b1;
				state_nx = ghnp_pkg::S_IDLE;
			end
			ghnp_pkg::S_Q_POS: begin
				ctl.pos_sel = 1'b1;
				state_nx = st.pos_skip ? ghnp_pkg::S_Q_ADV : ghnp_pkg::S_Q_FILL;
			end
			ghnp_pkg::S_Q_FILL: begin
				ctl.k_clear = 1'b1;
				state_nx = st.fill_zero ? ghnp_pkg::S_Q_ADV : ghnp_pkg::S_Q_SLOT;
			end
			ghnp_pkg::S_Q_SLOT: state_nx = ghnp_pkg::S_Q_PT;
			ghnp_pkg::S_Q_PT:   state_nx = ghnp_pkg::S_Q_SQ;
			ghnp_pkg::S_Q_SQ:   state_nx = ghnp_pkg::S_Q_CMP;
			ghnp_pkg::S_Q_CMP: begin
				ctl.cmp_en = 1'b1;
				state_nx = st.k_last ? ghnp_pkg::S_Q_ADV : ghnp_pkg::S_Q_SLOT;
			end
			ghnp_pkg::S_Q_ADV: begin
				if (st.pos_last) begin
					state_nx = ghnp_pkg::S_Q_SHELL;
				end else begin
					ctl.step = 1'b1;
					state_nx = ghnp_pkg::S_Q_POS;
				end
			end
			ghnp_pkg::S_Q_SHELL: begin
				if (st.stop_ok || st.shell_max) begin
					ctl.q_finish = 1'b1;
					state_nx = ghnp_pkg::S_IDLE;
				end else begin
					ctl.shell_next = 1'b1;
					state_nx = ghnp_pkg::S_Q_POS;
				end
			end
			default: state_nx = ghnp_pkg::S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

FILE: hdl/ghnp_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ghnp_dpath
// Point, slot and fill stores, shell walk counters, distance and best tracking.
// ----------------------------------------------------------------------------
module ghnp_dpath #(
	parameter int HASH_RES     = ghnp_pkg::HASH_RES_DEF,
	parameter int MAX_POINTS   = ghnp_pkg::MAX_POINTS_DEF,
	parameter int BUCKET_SLOTS = ghnp_pkg::BUCKET_SLOTS_DEF,
	parameter int MAX_SHELL    = ghnp_pkg::MAX_SHELL_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ghnp_pkg::ctl_t     ctl,
	output ghnp_pkg::stat_t         st,
	input  wire logic signed [15:0] px,
	input  wire logic signed [15:0] py,
	input  wire logic signed [15:0] pz,
	output logic                    done,
	output logic [1:0]              status,
	output logic [11:0]             point_index,
	output logic [31:0]             dist_sq
);

	localparam int NUM_BUCKETS = HASH_RES * HASH_RES * HASH_RES;
	localparam int NUM_SLOTS   = NUM_BUCKETS * BUCKET_SLOTS;
	localparam int BW  = $clog2(HASH_RES);
	localparam int HRW = $clog2(HASH_RES + 1);
	localparam int PW  = 16 + HRW;
	localparam int BKW = $clog2(NUM_BUCKETS);
	localparam int SAW = $clog2(NUM_SLOTS);
	localparam int FW  = $clog2(BUCKET_SLOTS + 1);
	localparam int IW  = $clog2(MAX_POINTS);
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int SHW = $clog2(MAX_SHELL + 2);
	localparam int OW  = SHW + 1;
	localparam int NW  = BW + SHW + 2;
	localparam int DW  = 34;
	localparam int RR  = HASH_RES * HASH_RES;
	localparam int PRW = DW + 11;

	function automatic logic [BW-1:0] axis_bkt(input logic signed [15:0] c);
		logic signed [17:0] v;
		logic [PW-1:0] p;
		logic [PW-16:0] b;
		v = 18'(c) + 18'sd16384;
		p = PW'(v[15:0]) * PW'(HASH_RES);
		b = p[PW-1:15];
		if (v < 0) return '0;
		if (b > (PW-15)'(HASH_RES - 1)) return BW'(HASH_RES - 1);
		return BW'(b);
	endfunction

	function automatic logic [BKW-1:0] flat_of(input logic [BW-1:0] a, input logic [BW-1:0] b,
		input logic [BW-1:0] c);
		return (BKW'(a) * BKW'(HASH_RES) + BKW'(b)) * BKW'(HASH_RES) + BKW'(c);
	endfunction

	function automatic logic [15:0] abs_diff(input logic signed [15:0] a,
		input logic signed [15:0] b);
		logic signed [16:0] d;
		logic signed [16:0] n;
		d = 17'(a) - 17'(b);
		n = -d;
		return d[16] ? n[15:0] : d[15:0];
	endfunction

	// captured item
	logic signed [15:0] x_q, y_q, z_q;
	logic [BW-1:0] bx_q, by_q, bz_q;

	// stores
	logic [47:0]   pt_mem   [MAX_POINTS];
	logic [IW-1:0] slot_mem [NUM_SLOTS];
	logic [FW-1:0] fill_mem [NUM_BUCKETS];
	logic [47:0]   pt_rd_q;
	logic [IW-1:0] slot_rd_q;
	logic [FW-1:0] fill_rd_q;

	logic [CW-1:0]  count_q;
	logic [BKW-1:0] clr_q;

	// walk
	logic [SHW-1:0]        shell_q;
	logic signed [OW-1:0]  dx_q, dy_q, dz_q;
	logic [BKW-1:0]        flat_q;
	logic [FW-1:0]         n_q, k_q;

	logic [31:0] sqx_q, sqy_q, sqz_q;
	logic        found_q;
	logic [DW-1:0]  best_q;
	logic [IW-1:0]  best_idx_q;
	logic [PRW-1:0] prod_q;

	logic [1:0]  status_q;
	logic [11:0] idx_q;
	logic [31:0] dist_q;
	logic        done_q;

	logic signed [OW-1:0] s, neg_s, s1;
	logic signed [NW-1:0] nx, ny, nz;
	logic in_rng, interior_xy, interior;
	logic [BKW-1:0] flat_pos, flat_ld;
	logic [BKW-1:0] fill_ra, fill_wa;
	logic [FW-1:0]  fill_wd;
	logic           fill_we;
	logic [DW-1:0]  d2;
	logic [2*SHW-1:0] sh_sq;
	logic [PRW-1:0] lim;

	assign s     = OW'(shell_q);
	assign neg_s = -s;
	assign s1    = s + OW'(1);

	assign nx = NW'(signed'({1'b0, bx_q})) + NW'(dx_q);
	assign ny = NW'(signed'({1'b0, by_q})) + NW'(dy_q);
	assign nz = NW'(signed'({1'b0, bz_q})) + NW'(dz_q);

	assign in_rng = (nx >= 0) && (nx < NW'(HASH_RES)) && (ny >= 0) && (ny < NW'(HASH_RES))
		&& (nz >= 0) && (nz < NW'(HASH_RES));
	assign interior_xy = (shell_q != '0) && (dx_q < s) && (dx_q > neg_s)
		&& (dy_q < s) && (dy_q > neg_s);
	assign interior = interior_xy && (dz_q < s) && (dz_q > neg_s);

	assign flat_pos = flat_of(nx[BW-1:0], ny[BW-1:0], nz[BW-1:0]);
	assign flat_ld  = flat_of(bx_q, by_q, bz_q);

	assign fill_ra = ctl.pos_sel ? flat_pos : flat_ld;
	assign fill_we = ctl.clr_en || ctl.ld_commit;
	assign fill_wa = ctl.clr_en ? clr_q : flat_ld;
	assign fill_wd = ctl.clr_en ? '0 : fill_rd_q + FW'(1);

	assign d2    = DW'(sqx_q) + DW'(sqy_q) + DW'(sqz_q);
	assign sh_sq = {{SHW{1'b0}}, shell_q} * {{SHW{1'b0}}, shell_q};
	assign lim   = PRW'(sh_sq) << 30;

	assign st.clr_last  = (clr_q == BKW'(NUM_BUCKETS - 1));
	assign st.full      = (count_q >= CW'(MAX_POINTS)) || (fill_rd_q >= FW'(BUCKET_SLOTS));
	assign st.pos_skip  = interior || !in_rng;
	assign st.fill_zero = (fill_rd_q == '0);
	assign st.k_last    = (k_q + FW'(1) == n_q);
	assign st.pos_last  = (dx_q == s) && (dy_q == s) && (dz_q == s);
	assign st.stop_ok   = found_q && (prod_q <= lim);
	assign st.shell_max = (shell_q == SHW'(MAX_SHELL));

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (fill_we) fill_mem[fill_wa] <= fill_wd;
		fill_rd_q <= fill_mem[fill_ra];
		if (ctl.ld_commit) begin
			pt_mem[count_q[IW-1:0]] <= {x_q, y_q, z_q};
			slot_mem[SAW'(flat_ld) * SAW'(BUCKET_SLOTS) + SAW'(fill_rd_q)] <= count_q[IW-1:0];
		end
		slot_rd_q <= slot_mem[SAW'(flat_q) * SAW'(BUCKET_SLOTS) + SAW'(k_q)];
		pt_rd_q   <= pt_mem[slot_rd_q];
	end

	// payload and walk registers
	always_ff @(posedge clk) begin
		sqx_q  <= abs_diff(pt_rd_q[47:32], x_q) * abs_diff(pt_rd_q[47:32], x_q);
		sqy_q  <= abs_diff(pt_rd_q[31:16], y_q) * abs_diff(pt_rd_q[31:16], y_q);
		sqz_q  <= abs_diff(pt_rd_q[15:0], z_q) * abs_diff(pt_rd_q[15:0], z_q);
		prod_q <= PRW'(best_q) * PRW'(RR);
		if (ctl.capture) begin
			x_q  <= px;
			y_q  <= py;
			z_q  <= pz;
			bx_q <= axis_bkt(px);
			by_q <= axis_bkt(py);
			bz_q <= axis_bkt(pz);
		end
		if (ctl.pos_sel) flat_q <= flat_pos;
		if (ctl.k_clear) begin
			n_q <= fill_rd_q;
			k_q <= '0;
		end else if (ctl.cmp_en) begin
			k_q <= k_q + FW'(1);
		end
		if (ctl.q_init) begin
			shell_q <= '0;
			dx_q <= '0;
			dy_q <= '0;
			dz_q <= '0;
			best_q <= '0;
			best_idx_q <= '0;
		end else if (ctl.shell_next) begin
			shell_q <= shell_q + SHW'(1);
			dx_q <= -s1;
			dy_q <= -s1;
			dz_q <= -s1;
		end else if (ctl.step) begin
			// jump over the inside of the shell along z
			if (interior_xy && dz_q == neg_s) begin
				dz_q <= s;
			end else if (dz_q == s) begin
				dz_q <= neg_s;
				if (dy_q == s) begin
					dy_q <= neg_s;
					dx_q <= dx_q + OW'(1);
				end else begin
					dy_q <= dy_q + OW'(1);
				end
			end else begin
				dz_q <= dz_q + OW'(1);
			end
		end
		if (ctl.cmp_en && (!found_q || d2 < best_q)) begin
			best_q <= d2;
			best_idx_q <= slot_rd_q;
		end
		if (ctl.ld_finish) begin
			if (st.full) begin
				status_q <= ghnp_pkg::ST_REJECTED;
				idx_q <= '0;
			end else begin
				status_q <= ghnp_pkg::ST_LOADED;
				idx_q <= 12'(count_q);
			end
			dist_q <= '0;
		end else if (ctl.q_finish) begin
			if (found_q) begin
				status_q <= ghnp_pkg::ST_FOUND;
				idx_q <= 12'(best_idx_q);
				dist_q <= (best_q[DW-1:32] != '0) ? 32'hFFFF_FFFF : best_q[31:0];
			end else begin
				status_q <= ghnp_pkg::ST_NONE;
				idx_q <= '0;
				dist_q <= '0;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			clr_q   <= '0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (ctl.clr_en) clr_q <= clr_q + BKW'(1);
			if (ctl.ld_commit) count_q <= count_q + CW'(1);
			if (ctl.q_init) found_q <= 1'b0;
			else if (ctl.cmp_en) found_q <= 1'b1;
			done_q <= ctl.ld_finish || ctl.q_finish;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign point_index = idx_q;
	assign dist_sq     = dist_q;

endmodule
`default_nettype wire
